>>> hw/rtl/bounded_ordered_list_top_assert.svh
// Assertion macros used by the checker of the ordered list.
// Each macro expects clock and reset to be visible where it is used.
`ifndef BOUNDED_ORDERED_LIST_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_TOP_ASSERT_SVH

// Same-cycle implication.
`define BOL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BOL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bol_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam int OP_W     = 2;
   localparam int INDEX_W  = 6;
   localparam int HANDLE_W = 16;
   localparam int LAYER_W  = 8;
   localparam int COUNT_W  = 6;

   localparam logic [OP_W-1:0] OP_INSERT_AT    = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT_LAYER = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE       = 2'd2;
   localparam logic [OP_W-1:0] OP_READ         = 2'd3;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic                ins_at;
      logic                ins_lay;
      logic                rem;
      logic [INDEX_W-1:0]  index;
      logic [HANDLE_W-1:0] handle;
      logic [LAYER_W-1:0]  layer;
   } cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/bounded_ordered_list_top.sv
// A result appears on the rsp_ ports in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, all cells shift in the same cycle.
// The cycle is set by the layer-compare chain that runs down the row of cells.
// Reset clears the entry count and the result strobe; entry storage is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module bounded_ordered_list_top #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [bol_pkg::OP_W-1:0]      req_op,
   input  wire  [bol_pkg::INDEX_W-1:0]   req_index,
   input  wire  [bol_pkg::HANDLE_W-1:0]  req_handle,
   input  wire  [bol_pkg::LAYER_W-1:0]   req_layer,
   output logic                          rsp_strobe,
   output logic                          rsp_ok,
   output logic [bol_pkg::HANDLE_W-1:0]  rsp_read_handle,
   output logic [bol_pkg::LAYER_W-1:0]   rsp_read_layer,
   output logic [bol_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_empty_res
);
   import bol_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int EW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [CW-1:0]       count_ff, count_in;
   logic                strobe_ff;
   logic                ok_ff, ok_in;
   logic [HANDLE_W-1:0] rh_ff, rh_in;
   logic [LAYER_W-1:0]  rl_ff, rl_in;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                empty_ff;

   logic                go;
   logic                full;
   logic [EW-1:0]       idx_e, cnt_e;
   logic [IW-1:0]       rd_sel;
   logic                ins_at_ok, ins_lay_ok, rem_ok, rd_ok;
   cmd_type             cmd;

   logic [HANDLE_W-1:0] hnd [CAPACITY];
   logic [LAYER_W-1:0]  lay [CAPACITY];
   logic                gt  [CAPACITY];
   logic                suf [CAPACITY];

   assign busy  = 1'b0;
   assign go    = start && !busy;
   assign full  = count_ff == CW'(CAPACITY);
   assign idx_e = EW'(req_index);
   assign cnt_e = EW'(count_ff);

   always_comb begin
      ins_at_ok  = 1'b0;
      ins_lay_ok = 1'b0;
      rem_ok     = 1'b0;
      rd_ok      = 1'b0;
      case (req_op)
         OP_INSERT_AT:    ins_at_ok  = go && !full && (idx_e <= cnt_e);
         OP_INSERT_LAYER: ins_lay_ok = go && !full;
         OP_REMOVE:       rem_ok     = go && (idx_e < cnt_e);
         OP_READ:         rd_ok      = go && (idx_e < cnt_e);
         default:         rd_ok      = 1'b0;
      endcase
   end

   assign cmd.ins_at  = ins_at_ok;
   assign cmd.ins_lay = ins_lay_ok;
   assign cmd.rem     = rem_ok;
   assign cmd.index   = req_index;
   assign cmd.handle  = req_handle;
   assign cmd.layer   = req_layer;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic [HANDLE_W-1:0] left_h, right_h;
         logic [LAYER_W-1:0]  left_l, right_l;
         logic                above_gt, below_gt;

         if (i == 0) begin : g_bottom
            assign left_h   = '0;
            assign left_l   = '0;
            assign below_gt = 1'b0;
         end else begin : g_inner_lo
            assign left_h   = hnd[i-1];
            assign left_l   = lay[i-1];
            assign below_gt = gt[i-1];
         end

         if (i == CAPACITY - 1) begin : g_top
            assign right_h  = '0;
            assign right_l  = '0;
            assign above_gt = 1'b1;
         end else begin : g_inner_hi
            assign right_h  = hnd[i+1];
            assign right_l  = lay[i+1];
            assign above_gt = suf[i+1];
         end

         bol_cell #(
            .POS (i),
            .CW  (CW)
         ) u_cell (
            .clock          (clock),
            .cmd            (cmd),
            .count_i        (count_ff),
            .left_handle_i  (left_h),
            .left_layer_i   (left_l),
            .right_handle_i (right_h),
            .right_layer_i  (right_l),
            .above_gt_i     (above_gt),
            .below_gt_i     (below_gt),
            .handle_o       (hnd[i]),
            .layer_o        (lay[i]),
            .gt_o           (gt[i]),
            .suf_o          (suf[i])
         );
      end
   endgenerate

   assign rd_sel = IW'(idx_e);

   always_comb begin
      count_in = count_ff;
      if (ins_at_ok || ins_lay_ok) begin
         count_in = count_ff + CW'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CW'(1);
      end
      ok_in = ins_at_ok || ins_lay_ok || rem_ok || rd_ok;
      rh_in = '0;
      rl_in = '0;
      if (rd_ok) begin
         rh_in = hnd[rd_sel];
         rl_in = lay[rd_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= go;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         ok_ff    <= ok_in;
         rh_ff    <= rh_in;
         rl_ff    <= rl_in;
         cnt_ff   <= COUNT_W'(count_in);
         empty_ff <= count_in == '0;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_read_handle = rh_ff;
   assign rsp_read_layer  = rl_ff;
   assign rsp_count       = cnt_ff;
   assign rsp_empty_res   = empty_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bol_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bol_cell #(
   parameter int POS = 0,
   parameter int CW  = $clog2(bol_pkg::CAPACITY_DEF + 1)
) (
   input  wire                                clock,
   input  bol_pkg::cmd_type                   cmd,
   input  wire  [CW-1:0]                      count_i,
   input  wire  [bol_pkg::HANDLE_W-1:0]       left_handle_i,
   input  wire  [bol_pkg::LAYER_W-1:0]        left_layer_i,
   input  wire  [bol_pkg::HANDLE_W-1:0]       right_handle_i,
   input  wire  [bol_pkg::LAYER_W-1:0]        right_layer_i,
   input  wire                                above_gt_i,
   input  wire                                below_gt_i,
   output logic [bol_pkg::HANDLE_W-1:0]       handle_o,
   output logic [bol_pkg::LAYER_W-1:0]        layer_o,
   output logic                               gt_o,
   output logic                               suf_o
);
   import bol_pkg::*;

   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [LAYER_W-1:0]  layer_ff, layer_in;
   logic                valid;
   logic                above_idx;
   logic                at_idx;

   assign valid     = count_i > CW'(POS);
   assign above_idx = POS > int'(cmd.index);
   assign at_idx    = POS == int'(cmd.index);

   // An empty slot counts as greater, so the suffix chain runs through it
   assign gt_o  = !valid || (layer_ff > cmd.layer);
   assign suf_o = above_gt_i && gt_o;

   always_comb begin
      handle_in = handle_ff;
      layer_in  = layer_ff;
      if (cmd.ins_at) begin
         if (above_idx) begin
            handle_in = left_handle_i;
            layer_in  = left_layer_i;
         end else if (at_idx) begin
            handle_in = cmd.handle;
            layer_in  = cmd.layer;
         end
      end else if (cmd.ins_lay) begin
         if (suf_o && below_gt_i) begin
            handle_in = left_handle_i;
            layer_in  = left_layer_i;
         end else if (suf_o) begin
            handle_in = cmd.handle;
            layer_in  = cmd.layer;
         end
      end else if (cmd.rem) begin
         if (above_idx || at_idx) begin
            handle_in = right_handle_i;
            layer_in  = right_layer_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      layer_ff  <= layer_in;
   end

   assign handle_o = handle_ff;
   assign layer_o  = layer_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bol_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_ordered_list_top_assert.svh"
module bol_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire [bol_pkg::OP_W-1:0]      req_op,
   input wire                          rsp_strobe,
   input wire                          rsp_ok,
   input wire [bol_pkg::HANDLE_W-1:0]  rsp_read_handle,
   input wire [bol_pkg::LAYER_W-1:0]   rsp_read_layer,
   input wire                          rsp_empty_res
);
   import bol_pkg::*;

   // Every accepted transaction yields a result in the next cycle
   `BOL_ASSERT_NXT(a_rsp_follows, start && !busy, rsp_strobe, "missing result")

   `BOL_ASSERT_IMP(a_rsp_caused, rsp_strobe, $past(start && !busy), "result without transaction")

   // Read fields stay zero unless a read succeeded
   `BOL_ASSERT_IMP(a_read_zero, rsp_strobe && !(rsp_ok && $past(req_op) == OP_READ), rsp_read_handle == '0 && rsp_read_layer == '0, "read fields not cleared")

   // A successful insert or read leaves the list non-empty
   `BOL_ASSERT_IMP(a_not_empty, rsp_strobe && rsp_ok && $past(req_op) != OP_REMOVE, !rsp_empty_res, "empty after insert or read")

endmodule

bind bounded_ordered_list_top bol_checker u_bol_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_op          (req_op),
   .rsp_strobe      (rsp_strobe),
   .rsp_ok          (rsp_ok),
   .rsp_read_handle (rsp_read_handle),
   .rsp_read_layer  (rsp_read_layer),
   .rsp_empty_res   (rsp_empty_res)
);
`default_nettype wire

>>> tb/sv/ordered_list_checker.sv
`timescale 1ns / 1ps
module ordered_list_checker #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire                           busy,
   input  wire  [bol_pkg::OP_W-1:0]      req_op,
   input  wire  [bol_pkg::INDEX_W-1:0]   req_index,
   input  wire  [bol_pkg::HANDLE_W-1:0]  req_handle,
   input  wire  [bol_pkg::LAYER_W-1:0]   req_layer,
   input  wire                           rsp_strobe,
   input  wire                           rsp_ok,
   input  wire  [bol_pkg::HANDLE_W-1:0]  rsp_read_handle,
   input  wire  [bol_pkg::LAYER_W-1:0]   rsp_read_layer,
   input  wire  [bol_pkg::COUNT_W-1:0]   rsp_count,
   input  wire                           rsp_empty_res,
   output int                            fail_count,
   output int                            outstanding
);
   import bol_pkg::*;

   typedef struct packed {
      logic                ok;
      logic [HANDLE_W-1:0] handle;
      logic [LAYER_W-1:0]  layer;
      logic [COUNT_W-1:0]  count;
      logic                empty;
   } list_outcome_type;

   logic [HANDLE_W-1:0] stored_handle [CAPACITY];
   logic [LAYER_W-1:0]  stored_layer  [CAPACITY];
   int                  stored_count = 0;
   list_outcome_type    outcome_q [$];
   int                  errs = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Move entries pos..count-1 up one place and fill the gap
   function automatic void open_slot(int pos, logic [HANDLE_W-1:0] h, logic [LAYER_W-1:0] l);
      for (int k = stored_count; k > pos; k--) begin
         stored_handle[k] = stored_handle[k-1];
         stored_layer[k]  = stored_layer[k-1];
      end
      stored_handle[pos] = h;
      stored_layer[pos]  = l;
      stored_count++;
   endfunction

   function automatic list_outcome_type apply_list_op(logic [OP_W-1:0] op,
                                                      logic [INDEX_W-1:0] idx,
                                                      logic [HANDLE_W-1:0] h,
                                                      logic [LAYER_W-1:0] l);
      list_outcome_type res;
      int               pos;
      res = '0;
      case (op)
         OP_INSERT_AT: begin
            if (stored_count < CAPACITY && int'(idx) <= stored_count) begin
               open_slot(int'(idx), h, l);
               res.ok = 1'b1;
            end
         end
         OP_INSERT_LAYER: begin
            if (stored_count < CAPACITY) begin
               // scan down from the last entry, past every greater layer
               pos = stored_count;
               while (pos > 0 && stored_layer[pos-1] > l) pos--;
               open_slot(pos, h, l);
               res.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (int'(idx) < stored_count) begin
               for (int k = int'(idx) + 1; k < stored_count; k++) begin
                  stored_handle[k-1] = stored_handle[k];
                  stored_layer[k-1]  = stored_layer[k];
               end
               stored_count--;
               res.ok = 1'b1;
            end
         end
         default: begin
            if (int'(idx) < stored_count) begin
               res.handle = stored_handle[idx];
               res.layer  = stored_layer[idx];
               res.ok     = 1'b1;
            end
         end
      endcase
      res.count = stored_count[COUNT_W-1:0];
      res.empty = (stored_count == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         stored_count = 0;
         outcome_q.delete();
      end else begin
         // push first so a same-edge result still finds its transaction
         if (start === 1'b1 && busy === 1'b0)
            outcome_q.push_back(apply_list_op(req_op, req_index, req_handle, req_layer));
         if (rsp_strobe !== 1'b0) begin
            if (outcome_q.size() == 0) begin
               $error("rsp_strobe: result with no transaction outstanding");
               errs++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
                  errs++;
               end
               if (rsp_read_handle !== want.handle) begin
                  $error("rsp_read_handle: expected 0x%04h, got 0x%04h",
                         want.handle, rsp_read_handle);
                  errs++;
               end
               if (rsp_read_layer !== want.layer) begin
                  $error("rsp_read_layer: expected %0d, got %0d", want.layer, rsp_read_layer);
                  errs++;
               end
               if (rsp_count !== want.count) begin
                  $error("rsp_count: expected %0d, got %0d", want.count, rsp_count);
                  errs++;
               end
               if (rsp_empty_res !== want.empty) begin
                  $error("rsp_empty_res: expected %0d, got %0d", want.empty, rsp_empty_res);
                  errs++;
               end
            end
         end
      end
      outstanding <= outcome_q.size();
      fail_count  <= errs;
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import bol_pkg::*;

   localparam int CAP         = CAPACITY_DEF;
   localparam int ITEM_TARGET = 1850;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_READS} phase_mode_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic [OP_W-1:0]     req_op     = '0;
   logic [INDEX_W-1:0]  req_index  = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic [LAYER_W-1:0]  req_layer  = '0;
   wire                 busy;
   wire                 rsp_strobe;
   wire                 rsp_ok;
   wire [HANDLE_W-1:0]  rsp_read_handle;
   wire [LAYER_W-1:0]   rsp_read_layer;
   wire [COUNT_W-1:0]   rsp_count;
   wire                 rsp_empty_res;
   int                  fail_count;
   int                  outstanding;

   int                  cycle_count = 0;
   int                  level = 0;     // entries held, tracked only to steer stimulus
   int                  sent = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_ordered_list_top #(.CAPACITY(CAP)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_index(req_index), .req_handle(req_handle),
      .req_layer(req_layer), .rsp_strobe(rsp_strobe), .rsp_ok(rsp_ok),
      .rsp_read_handle(rsp_read_handle), .rsp_read_layer(rsp_read_layer),
      .rsp_count(rsp_count), .rsp_empty_res(rsp_empty_res)
   );

   ordered_list_checker #(.CAPACITY(CAP)) list_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_index(req_index), .req_handle(req_handle),
      .req_layer(req_layer), .rsp_strobe(rsp_strobe), .rsp_ok(rsp_ok),
      .rsp_read_handle(rsp_read_handle), .rsp_read_layer(rsp_read_layer),
      .rsp_count(rsp_count), .rsp_empty_res(rsp_empty_res),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Issue one transaction; start stays high across back-to-back transactions
   task automatic issue(logic [OP_W-1:0] op, int idx, logic [HANDLE_W-1:0] h,
                        logic [LAYER_W-1:0] l, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_op     <= op;
      req_index  <= idx[INDEX_W-1:0];
      req_handle <= h;
      req_layer  <= l;
      do @(posedge clock); while (busy !== 1'b0);
      case (op)
         OP_INSERT_AT:    if (level < CAP && idx <= level) level++;
         OP_INSERT_LAYER: if (level < CAP) level++;
         OP_REMOVE:       if (idx < level) level--;
         default: ;
      endcase
      sent++;
   endtask

   function automatic logic [OP_W-1:0] pick_op(phase_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:
            return r < 45 ? OP_INSERT_AT : r < 85 ? OP_INSERT_LAYER :
                   r < 93 ? OP_READ : OP_REMOVE;
         MODE_DRAIN:
            return r < 10 ? OP_INSERT_AT : r < 20 ? OP_INSERT_LAYER :
                   r < 40 ? OP_READ : OP_REMOVE;
         MODE_READS:
            return r < 15 ? OP_INSERT_AT : r < 30 ? OP_INSERT_LAYER :
                   r < 40 ? OP_REMOVE : OP_READ;
         default:
            return r[1:0];
      endcase
   endfunction

   function automatic int pick_index(logic [OP_W-1:0] op);
      int r;
      bit ins;
      r   = $urandom_range(0, 9);
      ins = (op == OP_INSERT_AT || op == OP_INSERT_LAYER);
      if (r < 8) begin
         if (ins) return $urandom_range(0, level);
         return level > 0 ? $urandom_range(0, level - 1) : 0;
      end
      // edge of the valid range, or anywhere in the field
      if (r == 8) return ins ? level + 1 : level;
      return $urandom_range(0, 63);
   endfunction

   function automatic logic [LAYER_W-1:0] pick_layer();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return LAYER_W'($urandom_range(0, 7));   // crowd the keys to force ties
      if (r < 9) return LAYER_W'($urandom_range(0, 255));
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
   endfunction

   initial begin
      phase_mode_type   mode;
      int               run_len;
      bit               no_gap;
      logic [OP_W-1:0]  op;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: read, remove and an insert at index 1 are refused
      issue(OP_READ, 0, 16'h0000, 8'h00, 0);
      issue(OP_REMOVE, 0, 16'h0000, 8'h00, 0);
      issue(OP_INSERT_AT, 1, 16'h1234, 8'h05, 0);
      issue(OP_INSERT_LAYER, 0, 16'hFFFF, 8'hFF, 0);
      issue(OP_INSERT_LAYER, 0, 16'h0000, 8'h00, 1);
      issue(OP_INSERT_LAYER, 0, 16'hAAAA, 8'h80, 1);
      issue(OP_INSERT_LAYER, 63, 16'h5555, 8'h80, 0);   // equal layer lands after
      issue(OP_INSERT_AT, 0, 16'h0001, 8'hC8, 0);
      issue(OP_INSERT_AT, level, 16'h8000, 8'h01, 0);
      issue(OP_INSERT_AT, level + 1, 16'h7FFF, 8'h02, 1);
      issue(OP_INSERT_LAYER, 0, 16'h00FF, 8'h64, 0);     // last entry is lower: append
      issue(OP_INSERT_AT, 63, 16'hFF00, 8'h03, 0);
      for (int i = 0; i < 7; i++) issue(OP_READ, i, 16'h0000, 8'h00, i[0]);
      issue(OP_READ, level, 16'h0000, 8'h00, 0);
      issue(OP_READ, 63, 16'h0000, 8'h00, 1);
      issue(OP_REMOVE, level, 16'h0000, 8'h00, 0);
      issue(OP_REMOVE, level - 1, 16'h0000, 8'h00, 0);
      issue(OP_REMOVE, 0, 16'h0000, 8'h00, 1);
      issue(OP_REMOVE, 2, 16'h0000, 8'h00, 0);

      // first phase favours inserts, to push the list up to capacity
      mode    = MODE_FILL;
      run_len = 80;
      while (sent < ITEM_TARGET) begin
         no_gap = ($urandom_range(0, 9) < 3);
         for (int i = 0; i < run_len && sent < ITEM_TARGET; i++) begin
            op = pick_op(mode);
            issue(op, pick_index(op), 16'($urandom_range(0, 65535)), pick_layer(), no_gap);
         end
         mode    = phase_mode_type'($urandom_range(0, 3));
         run_len = $urandom_range(16, 96);
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
